>>> rtl/lru_age_utility_scorer_macros.svh
// Assertion macros shared by the checker of the LRU recency scorer.
// Every macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LRU_AGE_UTILITY_SCORER_MACROS_SVH
`define LRU_AGE_UTILITY_SCORER_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define LRAUS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru_age_utility_scorer: same-cycle property failed");

// Next-cycle implication, disabled while reset is applied.
`define LRAUS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru_age_utility_scorer: next-cycle property failed");

`endif

>>> rtl/lraus_pkg.sv
// Package for the LRU recency scorer: sizes, function codes and fixed-point constants.
// No dependencies; used by the top level and its checker.
`default_nettype none

package lraus_pkg;

	localparam int SLOTS     = 64;
	localparam int FRAC_BITS = 16;
	localparam int TIME_W    = 64;
	localparam int SLOT_W    = 6;
	localparam int FUNC_W    = 2;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int UTIL_W    = FRAC_BITS + 1;
	localparam int DIV_W     = $clog2(FRAC_BITS);

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [UTIL_W-1:0] util_t;

	localparam func_t FUNC_STORE = 2'd0;
	localparam func_t FUNC_ERASE = 2'd1;
	localparam func_t FUNC_QUERY = 2'd2;

	// 1.0 in the unsigned fixed-point score format.
	localparam util_t UTIL_ONE = util_t'(1) << FRAC_BITS;

endpackage

`default_nettype wire

>>> rtl/lraus_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the per-slot timestamps of the scorer.
`default_nettype none

module lraus_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/lru_age_utility_scorer.sv
// Top level of the LRU recency scorer: slot table, scan sequencer and fraction divider.
// Depends on lraus_pkg and the generic RAM lraus_ram.
// Store, erase, unused codes and queries of an absent or only entry: done in the cycle after start.
// A full query loads the queried time, scans the table and divides (not when equal times or the
// newest entry need none); the scan reads one RAM entry per cycle, the divider one bit per cycle.
// A new item may start in the cycle done is high. Reset clears valid marks, count and the score mode.
`default_nettype none

module lru_age_utility_scorer (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [lraus_pkg::FUNC_W-1:0]         func,
	input  wire  [lraus_pkg::SLOT_W-1:0]         slot,
	input  wire  [lraus_pkg::TIME_W-1:0]         timestamp,
	input  wire                                  cfg_we,
	input  wire                                  cfg_wdata,
	output logic                                 done,
	output logic [lraus_pkg::UTIL_W-1:0]         utility,
	output logic                                 present,
	output logic                                 degenerate
);

	localparam int IDX_W  = lraus_pkg::IDX_W;
	localparam int CNT_W  = lraus_pkg::CNT_W;
	localparam int TIME_W = lraus_pkg::TIME_W;
	localparam int FRAC   = lraus_pkg::FRAC_BITS;
	localparam int DIV_W  = lraus_pkg::DIV_W;

	// Sequencer states. A query walks LOADT -> SCAN -> SETUP and, unless it needs no division, DIV;
	// everything else finishes straight out of IDLE.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOADT = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_SETUP = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;

	localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(lraus_pkg::SLOTS);

	logic [2:0]            state_q;
	logic                  mode_q;
	logic                  valid_q [lraus_pkg::SLOTS];
	logic [CNT_W-1:0]      count_q;

	// Query context.
	logic [IDX_W-1:0]      slot_q;
	logic [TIME_W-1:0]     t_q;
	logic [TIME_W-1:0]     lo_q;
	logic [TIME_W-1:0]     hi_q;
	logic [CNT_W-1:0]      pos_q;

	// Scan pipeline: idx_q is the address being issued, the _s1 pair tags the data
	// that the RAM returns this cycle.
	logic [IDX_W:0]        idx_q;
	logic                  pend_s1;
	logic [IDX_W-1:0]      pend_j_s1;

	// Divider.
	logic [TIME_W-1:0]     rem_q;
	logic [TIME_W-1:0]     den_q;
	logic [FRAC-1:0]       quo_q;
	logic [DIV_W-1:0]      div_cnt_q;

	// Result registers.
	logic                  done_q;
	logic [lraus_pkg::UTIL_W-1:0] util_q;
	logic                  present_q;
	logic                  degen_q;

	// Input decode.
	logic                  accept;
	logic                  in_range;
	logic [IDX_W-1:0]      slot_idx;
	logic                  slot_valid;

	// RAM ports.
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_raddr;
	logic [TIME_W-1:0]     ram_rdata;

	// Scan compare and divider step.
	logic                  scan_lt_lo;
	logic                  scan_gt_hi;
	logic                  scan_before;
	logic                  rank_top;
	logic [TIME_W:0]       div_shift;
	logic [TIME_W+1:0]     div_diff;
	logic                  div_take;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign in_range   = (32'(slot) < lraus_pkg::SLOTS);
	assign slot_idx   = IDX_W'(slot);
	assign slot_valid = in_range && valid_q[slot_idx];

	assign done       = done_q;
	assign utility    = util_q;
	assign present    = present_q;
	assign degenerate = degen_q;

	assign ram_we = accept && (func == lraus_pkg::FUNC_STORE) && in_range;

	// The timestamp of the queried slot is read in the accept cycle, then the scan
	// walks addresses zero upward.
	always_comb begin
		case (state_q)
			ST_IDLE:  ram_raddr = slot_idx;
			ST_LOADT: ram_raddr = '0;
			default:  ram_raddr = idx_q[IDX_W-1:0];
		endcase
	end

	lraus_ram #(
		.WIDTH(TIME_W),
		.DEPTH(lraus_pkg::SLOTS)
	) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_idx),
		.wdata (timestamp),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Rank order: earlier time first, equal times broken by the lower slot index.
	assign scan_lt_lo  = (ram_rdata < lo_q);
	assign scan_gt_hi  = (ram_rdata > hi_q);
	assign scan_before = (ram_rdata < t_q) || ((ram_rdata == t_q) && (pend_j_s1 < slot_q));

	// The newest entry has every other live entry ahead of it in rank order.
	assign rank_top = (pos_q == (count_q - CNT_W'(1)));

	// One restoring step of the fraction divider; the extra top bit keeps the carry out
	// of the doubled remainder.
	assign div_shift = {rem_q, 1'b0};
	assign div_diff  = {1'b0, div_shift} - {2'b00, den_q};
	assign div_take  = !div_diff[TIME_W+1];

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			for (int i = 0; i < lraus_pkg::SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							lraus_pkg::FUNC_STORE: begin
								done_q <= 1'b1;
								if (in_range && !valid_q[slot_idx]) begin
									valid_q[slot_idx] <= 1'b1;
									count_q <= count_q + 1'b1;
								end
							end
							lraus_pkg::FUNC_ERASE: begin
								done_q <= 1'b1;
								if (slot_valid) begin
									valid_q[slot_idx] <= 1'b0;
									count_q <= count_q - 1'b1;
								end
							end
							lraus_pkg::FUNC_QUERY: begin
								if (slot_valid && (count_q != CNT_W'(1))) begin
									state_q <= ST_LOADT;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_LOADT: begin
					pend_s1 <= valid_q[0];
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (idx_q < SCAN_END) begin
						pend_s1 <= valid_q[idx_q[IDX_W-1:0]];
					end else begin
						pend_s1 <= 1'b0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if ((!mode_q && ((hi_q == lo_q) || (t_q == hi_q))) ||
							(mode_q && rank_top)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				slot_q    <= slot_idx;
				util_q    <= '0;
				present_q <= 1'b0;
				degen_q   <= 1'b0;
				if (accept && (func == lraus_pkg::FUNC_QUERY) && slot_valid) begin
					present_q <= 1'b1;
					if (count_q == CNT_W'(1)) begin
						util_q <= lraus_pkg::UTIL_ONE;
					end
				end
			end
			ST_LOADT: begin
				t_q       <= ram_rdata;
				lo_q      <= ram_rdata;
				hi_q      <= ram_rdata;
				pos_q     <= '0;
				idx_q     <= (IDX_W + 1)'(1);
				pend_j_s1 <= '0;
			end
			ST_SCAN: begin
				if (idx_q < SCAN_END) begin
					pend_j_s1 <= idx_q[IDX_W-1:0];
					idx_q     <= idx_q + 1'b1;
				end
				if (pend_s1) begin
					if (mode_q) begin
						if ((pend_j_s1 != slot_q) && scan_before) begin
							pos_q <= pos_q + 1'b1;
						end
					end else begin
						if (scan_lt_lo) begin
							lo_q <= ram_rdata;
						end
						if (scan_gt_hi) begin
							hi_q <= ram_rdata;
						end
					end
				end
			end
			ST_SETUP: begin
				div_cnt_q <= DIV_W'(FRAC - 1);
				quo_q     <= '0;
				if (mode_q) begin
					rem_q <= TIME_W'(pos_q);
					den_q <= TIME_W'(count_q - 1'b1);
					// The newest entry takes the full score without a division.
					if (rank_top) begin
						util_q <= lraus_pkg::UTIL_ONE;
					end
				end else begin
					rem_q <= t_q - lo_q;
					den_q <= hi_q - lo_q;
					// Several entries with one common time have no spread to scale by.
					if (hi_q == lo_q) begin
						degen_q <= 1'b1;
					end else if (t_q == hi_q) begin
						util_q <= lraus_pkg::UTIL_ONE;
					end
				end
			end
			ST_DIV: begin
				rem_q     <= div_take ? div_diff[TIME_W-1:0] : div_shift[TIME_W-1:0];
				quo_q     <= {quo_q[FRAC-2:0], div_take};
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == '0) begin
					util_q <= {1'b0, quo_q[FRAC-2:0], div_take};
				end
			end
			default: begin
				util_q <= util_q;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/lraus_checker.sv
// Port-level checker for the LRU recency scorer, bound to the top level.
// Depends on lraus_pkg and lru_age_utility_scorer_macros.svh.
`default_nettype none

`include "lru_age_utility_scorer_macros.svh"

module lraus_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          start,
	input wire                          busy,
	input wire                          done,
	input wire [lraus_pkg::UTIL_W-1:0]  utility,
	input wire                          present,
	input wire                          degenerate
);

	// An accepted item either answers at once or keeps the block busy.
	`LRAUS_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)

	// The sequencer hands back control in the same cycle that it shows the result.
	`LRAUS_ASSERT_IMPL(a_release_with_result, $fell(busy), done)

	// An absent slot or a non-query item carries an all-zero result.
	`LRAUS_ASSERT_IMPL(a_absent_zero, done && !present, (utility == '0) && !degenerate)

	// A flagged result belongs to a present entry and scores zero; no score exceeds 1.0.
	`LRAUS_ASSERT_IMPL(a_score_bounds, done,
		(utility <= lraus_pkg::UTIL_ONE) && (!degenerate || (present && (utility == '0))))

endmodule

bind lru_age_utility_scorer lraus_checker u_lraus_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.utility    (utility),
	.present    (present),
	.degenerate (degenerate)
);

`default_nettype wire
